// ----- rtl/ptss_pkg.sv -----
`default_nettype none
package ptss_pkg;

    // Table layout
    localparam int HEADER_BYTES = 36;
    // Offset of the closing underscore for a name that starts at the header end
    localparam int NAME_MIN     = HEADER_BYTES + 3;
    localparam int OFFS_W       = $clog2(NAME_MIN + 1);

    // Byte codes
    localparam logic [7:0]  PKG_OP      = 8'h12;
    localparam logic [7:0]  BYTE_PFX    = 8'h0A;
    localparam logic [7:0]  WORD_PFX    = 8'h0B;
    localparam logic [7:0]  SMALL_LIMIT = 8'd64;
    localparam logic [23:0] NAME_HEAD   = 24'h5F5335;
    localparam logic [7:0]  NAME_TAIL   = 8'h5F;

    // Sleep type position in the control word
    localparam int SLP_SHIFT = 10;
    localparam int SLP_W     = 16 - SLP_SHIFT;

    // Queue between classifier and parser
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One classified table byte
    typedef struct packed {
        logic [SLP_W-1:0] low_bits;   // byte bits that survive the shift
        logic [1:0]       len_code;   // extra package length bytes
        logic             is_pkg;
        logic             is_bpfx;
        logic             is_wpfx;
        logic             is_small;
        logic             name_hit;
        logic             last;
        logic             sum_zero;
    } cls_t;

endpackage
`default_nettype wire

// ----- rtl/ptss_front.sv -----
`default_nettype none
module ptss_front
    import ptss_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // table_byte
    input  wire logic       s_tlast,   // last_byte
    input  wire logic       q_ready,
    output logic            push,
    output cls_t            push_item
);

    logic [23:0]       recent_reg, recent_next;
    logic [OFFS_W-1:0] offs_reg, offs_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        sum_new;

    assign s_tready = q_ready;
    assign push     = s_tvalid && q_ready;
    assign sum_new  = sum_reg + s_tdata;

    always_comb
    begin
        push_item.low_bits = s_tdata[SLP_W-1:0];
        push_item.len_code = s_tdata[7:6];
        push_item.is_pkg   = (s_tdata == PKG_OP);
        push_item.is_bpfx  = (s_tdata == BYTE_PFX);
        push_item.is_wpfx  = (s_tdata == WORD_PFX);
        push_item.is_small = (s_tdata < SMALL_LIMIT);
        push_item.name_hit = (recent_reg == NAME_HEAD) && (s_tdata == NAME_TAIL)
                             && (offs_reg == OFFS_W'(NAME_MIN));
        push_item.last     = s_tlast;
        push_item.sum_zero = (sum_new == 8'd0);
    end

    always_comb
    begin
        recent_next = recent_reg;
        offs_next   = offs_reg;
        sum_next    = sum_reg;
        if (push)
        begin
            if (s_tlast)
            begin
                // start over for the next table
                recent_next = '0;
                offs_next   = '0;
                sum_next    = '0;
            end
            else
            begin
                recent_next = {recent_reg[15:0], s_tdata};
                sum_next    = sum_new;
                if (offs_reg != OFFS_W'(NAME_MIN))
                    offs_next = offs_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            offs_reg   <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            recent_reg <= recent_next;
            offs_reg   <= offs_next;
            sum_reg    <= sum_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ptss_queue.sv -----
`default_nettype none
module ptss_queue
    import ptss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cls_t push_item,
    output logic      q_ready,
    input  wire logic pop,
    output logic      q_valid,
    output cls_t      q_item
);

    cls_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign q_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ptss_back.sv -----
`default_nettype none
module ptss_back
    import ptss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire cls_t        q_item,
    output logic             pop,
    input  wire logic [2:0]  dflt_type,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // sleep_word_a, sleep_word_b
    output logic [1:0]       m_tuser    // checksum_ok, entry_found
);

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_SCAN,
        PH_PKGLEN,
        PH_PKGSKIP,
        PH_COUNT,
        PH_ELEM1,
        PH_A_BYTE,
        PH_A_WLO,
        PH_A_WHI,
        PH_ELEM2,
        PH_B_BYTE,
        PH_DONE
    } phase_t;

    phase_t           phase_reg, phase_next, phase_upd;
    logic [1:0]       skip_reg, skip_next, skip_upd;
    logic [SLP_W-1:0] cap_a_reg, cap_a_next, cap_a_upd;
    logic [SLP_W-1:0] cap_b_reg, cap_b_next, cap_b_upd;
    logic             out_valid_reg, out_valid_next;
    logic             ok_reg, ok_next;
    logic             found_reg, found_next;
    logic [15:0]      word_a_reg, word_a_next;
    logic [15:0]      word_b_reg, word_b_next;
    logic             found;

    assign pop      = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {word_b_reg, word_a_reg};
    assign m_tuser  = {found_reg, ok_reg};
    assign found    = !(phase_reg inside {PH_SEARCH, PH_SCAN, PH_PKGLEN});

    // Advance the parse by one byte
    always_comb
    begin
        phase_upd = phase_reg;
        skip_upd  = skip_reg;
        cap_a_upd = cap_a_reg;
        cap_b_upd = cap_b_reg;
        case (phase_reg)
            PH_SEARCH:
                if (q_item.name_hit)
                    phase_upd = PH_SCAN;
            PH_SCAN:
                if (q_item.is_pkg)
                    phase_upd = PH_PKGLEN;
            PH_PKGLEN:
            begin
                skip_upd  = q_item.len_code;
                phase_upd = (q_item.len_code == 2'd0) ? PH_COUNT : PH_PKGSKIP;
            end
            PH_PKGSKIP:
            begin
                skip_upd = skip_reg - 1'b1;
                if (skip_upd == 2'd0)
                    phase_upd = PH_COUNT;
            end
            PH_COUNT:
                phase_upd = PH_ELEM1;
            PH_ELEM1:
                if (q_item.is_bpfx)
                    phase_upd = PH_A_BYTE;
                else if (q_item.is_wpfx)
                    phase_upd = PH_A_WLO;
                else if (q_item.is_small)
                begin
                    cap_a_upd = q_item.low_bits;
                    phase_upd = PH_ELEM2;
                end
                else
                begin
                    cap_a_upd = '0;
                    cap_b_upd = '0;
                    phase_upd = PH_DONE;
                end
            PH_A_BYTE:
            begin
                cap_a_upd = q_item.low_bits;
                phase_upd = PH_ELEM2;
            end
            PH_A_WLO:
            begin
                cap_a_upd = q_item.low_bits;
                phase_upd = PH_A_WHI;
            end
            PH_A_WHI:
                phase_upd = PH_ELEM2;
            PH_ELEM2:
                if (q_item.is_bpfx)
                    phase_upd = PH_B_BYTE;
                else
                begin
                    cap_b_upd = q_item.is_small ? q_item.low_bits : '0;
                    phase_upd = PH_DONE;
                end
            PH_B_BYTE:
            begin
                cap_b_upd = q_item.low_bits;
                phase_upd = PH_DONE;
            end
            default:
                phase_upd = PH_DONE;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        cap_a_next     = cap_a_reg;
        cap_b_next     = cap_b_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ok_next        = ok_reg;
        found_next     = found_reg;
        word_a_next    = word_a_reg;
        word_b_next    = word_b_reg;
        if (pop)
        begin
            phase_next = phase_upd;
            skip_next  = skip_upd;
            cap_a_next = cap_a_upd;
            cap_b_next = cap_b_upd;
            if (q_item.last)
            begin
                out_valid_next = 1'b1;
                ok_next        = q_item.sum_zero;
                found_next     = found;
                word_a_next    = found ? {cap_a_upd, SLP_SHIFT'(0)}
                                       : {(SLP_W - 3)'(0), dflt_type, SLP_SHIFT'(0)};
                word_b_next    = found ? {cap_b_upd, SLP_SHIFT'(0)}
                                       : {(SLP_W - 3)'(0), dflt_type, SLP_SHIFT'(0)};
                // drop the parse state for the next table
                phase_next = PH_SEARCH;
                skip_next  = '0;
                cap_a_next = '0;
                cap_b_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            skip_reg      <= '0;
            cap_a_reg     <= '0;
            cap_b_reg     <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            found_reg     <= 1'b0;
            word_a_reg    <= '0;
            word_b_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            cap_a_reg     <= cap_a_next;
            cap_b_reg     <= cap_b_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            found_reg     <= found_next;
            word_a_reg    <= word_a_next;
            word_b_reg    <= word_b_next;
        end
    end

    a_skip_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PKGSKIP) |-> (skip_reg != 2'd0))
        else $error("package skip with no bytes left");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.last) |=> (phase_reg == PH_SEARCH && cap_a_reg == '0))
        else $error("parse not restarted after last byte");

    a_default: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (word_a_reg == word_b_reg))
        else $error("default words differ");

endmodule
`default_nettype wire

// ----- rtl/power_table_sleep_type_scanner.sv -----
`default_nettype none
// Path: each accepted table byte is written into the queue and read from it by
//   the parser, which registers the result for the master side on the last byte.
// Throughput: one byte per cycle unless a result waits on m_tready; set by the
//   parse step, one byte per pop, and the two-entry queue after the classifier.
// Reset: rst_n clears the parse, the sum and the queue at once; the default
//   sleep type returns to 5. No clearing pass is needed.
module power_table_sleep_type_scanner
    import ptss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] table_byte
    input  wire logic        s_tlast,    // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [15:0] sleep_word_a, [31:16] sleep_word_b
    output logic [1:0]       m_tuser,    // [0] checksum_ok, [1] entry_found
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data    // [2:0] default_sleep_type
);

    logic [2:0] dflt_type_reg;
    logic       push;
    cls_t       push_item;
    logic       q_ready;
    logic       pop;
    logic       q_valid;
    cls_t       q_item;

    // Take a configuration write in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dflt_type_reg <= 3'd5;
        else if (cfg_valid && cfg_ready)
            dflt_type_reg <= cfg_data;
    end

    // Front: hold the name window, offset and byte sum; classify each item
    ptss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_ready   (q_ready),
        .push      (push),
        .push_item (push_item)
    );

    // Queue: let the front keep taking items while the result side stalls, until the queue is full
    ptss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Back: walk the package phases and register the result on the last item
    ptss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .dflt_type (dflt_type_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

// ----- sim/ptss_report_checker.sv -----
`timescale 1ns / 1ps
module ptss_report_checker
    import ptss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] table_byte
    input  wire logic        s_tlast,    // last_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,    // [15:0] sleep_word_a, [31:16] sleep_word_b
    input  wire logic [1:0]  m_tuser,    // [0] checksum_ok, [1] entry_found
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_data,   // [2:0] default_sleep_type
    output int               error_count,
    output int               results_taken,
    output int               reports_waiting,
    output int               entries_found
);

    localparam int OFFSET_CEIL = 1048575;

    typedef enum logic [3:0] {
        SEEK_NAME,
        SEEK_PKG,
        PKG_LEN,
        PKG_SKIP,
        ELEM_COUNT,
        ELEM_A,
        A_BYTE,
        A_WORD_LO,
        A_WORD_HI,
        ELEM_B,
        B_BYTE,
        SCAN_DONE
    } scan_phase_t;

    typedef struct packed {
        logic        checksum_ok;
        logic        entry_found;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } scan_report_t;

    scan_phase_t  phase;
    logic [19:0]  byte_offset;
    logic [7:0]   byte_total;
    logic [23:0]  recent;
    logic [1:0]   skip_left;
    logic [15:0]  word_a;
    logic [15:0]  word_b;
    logic [2:0]   default_type;
    scan_report_t expected_reports[$];

    function automatic logic [15:0] sleep_word(input logic [7:0] v);
        return {8'h00, v} << SLP_SHIFT;
    endfunction

    task automatic clear_scan();
        phase       = SEEK_NAME;
        byte_offset = '0;
        byte_total  = '0;
        recent      = '0;
        skip_left   = '0;
        word_a      = '0;
        word_b      = '0;
    endtask

    // Advance the parse by one table byte; queue a report on the closing byte.
    task automatic scan_table_byte(input logic [7:0] b, input logic last);
        scan_phase_t  prior;
        scan_report_t rep;
        logic         found;
        prior      = phase;
        byte_total = byte_total + b;
        case (phase)
            SEEK_NAME:
                if (recent == NAME_HEAD && b == NAME_TAIL && byte_offset >= NAME_MIN)
                    phase = SEEK_PKG;
            SEEK_PKG:
                if (b == PKG_OP)
                    phase = PKG_LEN;
            PKG_LEN:
            begin
                skip_left = b[7:6];
                phase     = (skip_left == 2'd0) ? ELEM_COUNT : PKG_SKIP;
            end
            PKG_SKIP:
            begin
                skip_left = skip_left - 2'd1;
                if (skip_left == 2'd0)
                    phase = ELEM_COUNT;
            end
            ELEM_COUNT:
                phase = ELEM_A;
            ELEM_A:
                if (b == BYTE_PFX)
                    phase = A_BYTE;
                else if (b == WORD_PFX)
                    phase = A_WORD_LO;
                else if (b < SMALL_LIMIT)
                begin
                    word_a = sleep_word(b);
                    phase  = ELEM_B;
                end
                else
                begin
                    word_a = '0;
                    word_b = '0;
                    phase  = SCAN_DONE;
                end
            A_BYTE:
            begin
                word_a = sleep_word(b);
                phase  = ELEM_B;
            end
            A_WORD_LO:
            begin
                word_a = sleep_word(b);
                phase  = A_WORD_HI;
            end
            A_WORD_HI:
                phase = ELEM_B;
            ELEM_B:
                if (b == BYTE_PFX)
                    phase = B_BYTE;
                else
                begin
                    word_b = (b < SMALL_LIMIT) ? sleep_word(b) : 16'h0000;
                    phase  = SCAN_DONE;
                end
            B_BYTE:
            begin
                word_b = sleep_word(b);
                phase  = SCAN_DONE;
            end
            default:
                phase = SCAN_DONE;
        endcase
        recent = {recent[15:0], b};
        if (byte_offset < OFFSET_CEIL)
            byte_offset = byte_offset + 20'd1;

        if (last)
        begin
            found           = !(prior == SEEK_NAME || prior == SEEK_PKG || prior == PKG_LEN);
            rep.checksum_ok = (byte_total == 8'h00);
            rep.entry_found = found;
            rep.word_a      = found ? word_a : sleep_word({5'b0, default_type});
            rep.word_b      = found ? word_b : sleep_word({5'b0, default_type});
            expected_reports.push_back(rep);
            if (found)
                entries_found++;
            clear_scan();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_report();
        scan_report_t want;
        results_taken++;
        if (expected_reports.size() == 0)
        begin
            report_mismatch("result with no table pending", m_tdata, 32'h0);
            return;
        end
        want = expected_reports.pop_front();
        if (m_tuser[0] !== want.checksum_ok)
            report_mismatch("checksum_ok", 32'(m_tuser[0]), 32'(want.checksum_ok));
        if (m_tuser[1] !== want.entry_found)
            report_mismatch("entry_found", 32'(m_tuser[1]), 32'(want.entry_found));
        if (m_tdata[15:0] !== want.word_a)
            report_mismatch("sleep_word_a", 32'(m_tdata[15:0]), 32'(want.word_a));
        if (m_tdata[31:16] !== want.word_b)
            report_mismatch("sleep_word_b", 32'(m_tdata[31:16]), 32'(want.word_b));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            default_type = 3'd5;
            expected_reports.delete();
            error_count   = 0;
            results_taken = 0;
            entries_found = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                default_type = cfg_data;
            if (s_tvalid && s_tready)
                scan_table_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_report();
        end
        reports_waiting = expected_reports.size();
    end

endmodule

// ----- sim/power_table_sleep_type_scanner_tb.sv -----
`timescale 1ns / 1ps
module power_table_sleep_type_scanner_tb;
    import ptss_pkg::*;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         STALL_CYCLES = 80;
    localparam int         PHASE_BYTES  = 80;
    localparam int         PHASE_TABLES = 3;
    localparam logic [7:0] NAME_OP      = 8'h08;

    // How a package element is laid out in the table
    typedef enum int {
        ELEM_SMALL,
        ELEM_BYTE,
        ELEM_WORD,
        ELEM_WIDE,
        ELEM_NONE
    } elem_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] table_byte
    logic        s_tlast;    // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [15:0] sleep_word_a, [31:16] sleep_word_b
    logic [1:0]  m_tuser;    // [0] checksum_ok, [1] entry_found
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;   // [2:0] default_sleep_type

    int error_count;
    int results_taken;
    int reports_waiting;
    int entries_found;

    int         bytes_sent;
    int         tables_sent;
    int         cfg_writes;
    int         cycle_count;
    bit         no_idle;
    bit         stall_request;
    logic [7:0] image_bytes[$];

    power_table_sleep_type_scanner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    ptss_report_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .error_count    (error_count),
        .results_taken  (results_taken),
        .reports_waiting(reports_waiting),
        .entries_found  (entries_found)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Watchdog: end the run if the handshakes never complete.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d reports outstanding",
                 cycle_count, tables_sent - results_taken);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: accept at random, never idle during the unpaced stretch,
    // and hold off for a long fixed stretch when the stimulus asks for it.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= no_idle || ($urandom_range(99) >= 20);
            end
        end
    end

    // Offer one table byte, with random idle cycles ahead of it, and hold it
    // until the block takes it. Valid stays high afterwards so that the next
    // item follows without a bubble; park the sender before any pause.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic park_sender();
        s_tvalid <= 1'b0;
    endtask

    task automatic send_image();
        foreach (image_bytes[i])
            send_byte(image_bytes[i], i == image_bytes.size() - 1);
        tables_sent++;
    endtask

    // Fix up the first header byte so the table sums to zero, or spoil it on
    // purpose. Byte 0 never takes part in a name that counts.
    task automatic seal_image(input logic sum_ok);
        logic [7:0] total;
        total = 8'h00;
        foreach (image_bytes[i])
            total = total + image_bytes[i];
        image_bytes[0] = image_bytes[0] - total;
        if (!sum_ok)
            image_bytes[0] = image_bytes[0] + 8'($urandom_range(1, 255));
    endtask

    task automatic push_element(input elem_kind_t kind, input logic [15:0] val);
        logic [7:0] wide;
        case (kind)
            ELEM_SMALL:
                image_bytes.push_back({2'b00, val[5:0]});
            ELEM_BYTE:
            begin
                image_bytes.push_back(BYTE_PFX);
                image_bytes.push_back(val[7:0]);
            end
            ELEM_WORD:
            begin
                image_bytes.push_back(WORD_PFX);
                image_bytes.push_back(val[7:0]);
                image_bytes.push_back(val[15:8]);
            end
            ELEM_WIDE:
            begin
                // Any byte of 64 or more is neither prefix
                wide = val[7:0];
                if (wide < SMALL_LIMIT)
                    wide = wide + SMALL_LIMIT;
                image_bytes.push_back(wide);
            end
            default:
                ;
        endcase
    endtask

    // Lay out header, lead, name, scan fill, package op, length and its extra bytes,
    // count, both elements and tail. A nonzero cut truncates the table to that many bytes.
    task automatic build_entry_table(
        input int         head_len,
        input int         lead,
        input int         scan_fill,
        input logic [1:0] len_extra,
        input elem_kind_t kind_a,
        input logic [15:0] val_a,
        input elem_kind_t kind_b,
        input logic [15:0] val_b,
        input int         tail,
        input int         cut
    );
        logic [7:0] fill;
        image_bytes.delete();
        repeat (head_len + lead)
            image_bytes.push_back(8'($urandom));
        image_bytes.push_back(NAME_HEAD[23:16]);
        image_bytes.push_back(NAME_HEAD[15:8]);
        image_bytes.push_back(NAME_HEAD[7:0]);
        image_bytes.push_back(NAME_TAIL);
        // Bytes the package scan passes over: name ops and random bytes other than the package op
        repeat (scan_fill)
        begin
            fill = ($urandom_range(1) != 0) ? NAME_OP : 8'($urandom);
            if (fill == PKG_OP)
                fill = NAME_OP;
            image_bytes.push_back(fill);
        end
        image_bytes.push_back(PKG_OP);
        image_bytes.push_back({len_extra, 6'($urandom)});
        repeat (len_extra)
            image_bytes.push_back(8'($urandom));
        image_bytes.push_back(8'($urandom));
        push_element(kind_a, val_a);
        push_element(kind_b, val_b);
        repeat (tail)
            image_bytes.push_back(8'($urandom));
        while (cut > 0 && image_bytes.size() > cut)
            void'(image_bytes.pop_back());
    endtask

    task automatic random_entry_table();
        int         head_len;
        int         cut;
        elem_kind_t kind_a;
        elem_kind_t kind_b;
        // Now and then shorten the header by one byte, which puts the name inside it when there is no lead
        head_len = ($urandom_range(9) == 0) ? HEADER_BYTES - 1 : HEADER_BYTES;
        kind_a   = elem_kind_t'($urandom_range(3));
        case ($urandom_range(3))
            0:       kind_b = ELEM_SMALL;
            1:       kind_b = ELEM_BYTE;
            2:       kind_b = ELEM_WIDE;
            default: kind_b = ELEM_NONE;
        endcase
        // Break off some tables part way through the name or the package
        cut = ($urandom_range(99) < 20) ? $urandom_range(38, 52) : 0;
        build_entry_table(head_len, $urandom_range(0, 4), $urandom_range(0, 4),
                          2'($urandom), kind_a, 16'($urandom), kind_b, 16'($urandom),
                          $urandom_range(0, 3), cut);
        seal_image($urandom_range(9) != 0);
        send_image();
    endtask

    task automatic random_noise_table();
        image_bytes.delete();
        repeat ($urandom_range(1, 24))
            image_bytes.push_back(8'($urandom));
        seal_image($urandom_range(1) != 0);
        send_image();
    endtask

    // Stall the result side and feed twelve one-byte tables, each of which makes
    // a report, so that the block backs up and drops its input ready.
    task automatic overfill_output();
        stall_request = 1'b1;
        no_idle       = 1'b1;
        repeat (12)
        begin
            image_bytes.delete();
            image_bytes.push_back(8'($urandom));
            seal_image($urandom_range(1) != 0);
            send_image();
        end
        no_idle = 1'b0;
    endtask

    task automatic write_default_type(input logic [2:0] sleep_type);
        cfg_valid <= 1'b1;
        cfg_data  <= sleep_type;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Drain every report and let the parser settle, then change the default
    // while the block is idle.
    task automatic settle_and_configure(input logic [2:0] sleep_type);
        park_sender();
        wait (results_taken >= tables_sent);
        repeat (4) @(posedge clk);
        write_default_type(sleep_type);
    endtask

    initial
    begin
        int round;
        int start_bytes;
        int start_tables;

        bytes_sent    = 0;
        tables_sent   = 0;
        cfg_writes    = 0;
        no_idle       = 1'b0;
        stall_request = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 3'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed tables, run under the reset default.
        // Name starting exactly at the end of the header; small elements 0 and 63
        build_entry_table(HEADER_BYTES, 0, 0, 2'd0, ELEM_SMALL, 16'h0000,
                          ELEM_SMALL, 16'h003F, 0, 0);
        seal_image(1'b1);
        send_image();
        // Name starting one byte inside the header is ignored
        build_entry_table(HEADER_BYTES - 1, 0, 0, 2'd0, ELEM_SMALL, 16'h0003,
                          ELEM_SMALL, 16'h0004, 2, 0);
        seal_image(1'b1);
        send_image();
        // Table ends on the closing underscore of the name
        build_entry_table(HEADER_BYTES, 2, 0, 2'd0, ELEM_SMALL, 16'h0001,
                          ELEM_SMALL, 16'h0002, 0, HEADER_BYTES + 6);
        seal_image(1'b1);
        send_image();
        // Package op as the final byte, then as the one before it: too late
        build_entry_table(HEADER_BYTES, 0, 1, 2'd0, ELEM_SMALL, 16'h0001,
                          ELEM_SMALL, 16'h0002, 0, HEADER_BYTES + 6);
        seal_image(1'b1);
        send_image();
        build_entry_table(HEADER_BYTES, 0, 1, 2'd0, ELEM_SMALL, 16'h0001,
                          ELEM_SMALL, 16'h0002, 0, HEADER_BYTES + 7);
        seal_image(1'b1);
        send_image();
        // Package op three from the end counts; nothing decoded yet
        build_entry_table(HEADER_BYTES, 0, 1, 2'd0, ELEM_SMALL, 16'h0001,
                          ELEM_SMALL, 16'h0002, 0, HEADER_BYTES + 8);
        seal_image(1'b1);
        send_image();
        // Longest package length, name ops in the scan, byte prefixes at the top
        build_entry_table(HEADER_BYTES, 1, 4, 2'd3, ELEM_BYTE, 16'h00FF,
                          ELEM_BYTE, 16'h0080, 2, 0);
        seal_image(1'b1);
        send_image();
        // Word prefix: only the low data byte survives
        build_entry_table(HEADER_BYTES, 0, 1, 2'd1, ELEM_WORD, 16'hA5FF,
                          ELEM_SMALL, 16'h003F, 1, 0);
        seal_image(1'b1);
        send_image();
        // Unknown first element at both ends of its range
        build_entry_table(HEADER_BYTES, 0, 0, 2'd2, ELEM_WIDE, 16'h0040,
                          ELEM_SMALL, 16'h0005, 1, 0);
        seal_image(1'b1);
        send_image();
        build_entry_table(HEADER_BYTES, 0, 0, 2'd0, ELEM_WIDE, 16'h00FF,
                          ELEM_SMALL, 16'h0005, 0, 0);
        seal_image(1'b1);
        send_image();
        // Second element too wide to decode
        build_entry_table(HEADER_BYTES, 0, 0, 2'd0, ELEM_SMALL, 16'h0001,
                          ELEM_WIDE, 16'h00FF, 1, 0);
        seal_image(1'b1);
        send_image();
        // Table ends on the low byte of a word element
        build_entry_table(HEADER_BYTES, 0, 0, 2'd0, ELEM_WORD, 16'h1234,
                          ELEM_NONE, 16'h0000, 0, HEADER_BYTES + 9);
        seal_image(1'b1);
        send_image();
        // Table ends after the first element, and on the second's byte prefix
        build_entry_table(HEADER_BYTES, 0, 0, 2'd0, ELEM_SMALL, 16'h0007,
                          ELEM_NONE, 16'h0000, 0, 0);
        seal_image(1'b1);
        send_image();
        build_entry_table(HEADER_BYTES, 0, 0, 2'd0, ELEM_SMALL, 16'h0009,
                          ELEM_BYTE, 16'h00AA, 0, HEADER_BYTES + 9);
        seal_image(1'b1);
        send_image();
        // Bad checksum still reports the decoded entry
        build_entry_table(HEADER_BYTES, 0, 0, 2'd0, ELEM_BYTE, 16'h0011,
                          ELEM_SMALL, 16'h0022, 1, 0);
        seal_image(1'b0);
        send_image();
        // One-byte tables at the byte extremes
        image_bytes.delete();
        image_bytes.push_back(8'h00);
        send_image();
        image_bytes.delete();
        image_bytes.push_back(8'hFF);
        send_image();
        // Long table: the name sits far past any small offset counter
        build_entry_table(HEADER_BYTES, 100, 2, 2'd1, ELEM_BYTE, 16'h0042,
                          ELEM_SMALL, 16'h0021, 1, 0);
        seal_image(1'b1);
        send_image();

        // Random phases, each under its own default sleep type; the second
        // runs unpaced on both sides, the fourth starts by backing up the block.
        for (round = 0; round < 5; round++)
        begin
            case (round)
                0:       settle_and_configure(3'd0);
                1:       settle_and_configure(3'd7);
                default: settle_and_configure(3'($urandom));
            endcase
            no_idle = (round == 1);
            if (round == 3)
            begin
                overfill_output();
                park_sender();
                wait (results_taken >= tables_sent);
            end
            start_bytes  = bytes_sent;
            start_tables = tables_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES ||
                   tables_sent - start_tables < PHASE_TABLES)
            begin
                if ($urandom_range(99) < 60)
                    random_entry_table();
                else
                    random_noise_table();
            end
            no_idle = 1'b0;
        end

        park_sender();
        wait (results_taken >= tables_sent);
        repeat (10) @(posedge clk);

        $display("Sent %0d table bytes in %0d tables; %0d sleep entries decoded,",
                 bytes_sent, tables_sent, entries_found);
        $display("%0d default type writes, one long output stall and one unpaced phase.",
                 cfg_writes);
        if (error_count == 0 && reports_waiting == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ptss_pkg.sv
rtl/ptss_front.sv
rtl/ptss_queue.sv
rtl/ptss_back.sv
rtl/power_table_sleep_type_scanner.sv
sim/ptss_report_checker.sv
sim/power_table_sleep_type_scanner_tb.sv
